### rtl/core/source_text_tokenizer_defines.svh
// source_text_tokenizer_defines.svh: assertion macros for the tokenizer RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define STT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define STT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### rtl/core/stt_pkg.sv
// stt_pkg: token kinds, character codes, result type and character-class helpers.
// Shared by the tokenizer top level and its result queue; no dependencies.
package stt_pkg;

	localparam int OFS_W       = 16;
	localparam int LEN_W       = 16;
	localparam int VAL_W       = 64;
	localparam int KIND_W      = 5;
	localparam int KW_MAX_LEN  = 6;
	localparam int KW_IDX_W    = $clog2(KW_MAX_LEN);
	localparam int FIFO_DEPTH  = 8;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [KW_MAX_LEN-1:0][7:0] prefix_t;

	// Token kinds
	localparam kind_t KIND_EOF        = 5'd0;
	localparam kind_t KIND_COMMA      = 5'd1;
	localparam kind_t KIND_LPAREN     = 5'd2;
	localparam kind_t KIND_RPAREN     = 5'd3;
	localparam kind_t KIND_LBRACE     = 5'd4;
	localparam kind_t KIND_RBRACE     = 5'd5;
	localparam kind_t KIND_EQUALS     = 5'd6;
	localparam kind_t KIND_PLUS       = 5'd7;
	localparam kind_t KIND_MINUS      = 5'd8;
	localparam kind_t KIND_STAR       = 5'd9;
	localparam kind_t KIND_SLASH      = 5'd10;
	localparam kind_t KIND_SEMI       = 5'd11;
	localparam kind_t KIND_ARROW      = 5'd12;
	localparam kind_t KIND_EQUALITY   = 5'd13;
	localparam kind_t KIND_INEQUALITY = 5'd14;
	localparam kind_t KIND_INTEGER    = 5'd15;
	localparam kind_t KIND_IDENT      = 5'd16;
	localparam kind_t KIND_KW_FUNC    = 5'd17;
	localparam kind_t KIND_KW_VAR     = 5'd18;
	localparam kind_t KIND_KW_IF      = 5'd19;
	localparam kind_t KIND_KW_RETURN  = 5'd20;
	localparam kind_t KIND_KW_CHAR    = 5'd21;
	localparam kind_t KIND_KW_INT     = 5'd22;
	localparam kind_t KIND_ERROR      = 5'd23;

	// Character codes with special meaning
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// One result item
	typedef struct packed {
		kind_t             kind;
		logic [VAL_W-1:0]  value;
		logic [OFS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              last;
	} res_t;

	function automatic res_t mk_res(kind_t kind, logic [VAL_W-1:0] value,
		logic [OFS_W-1:0] start, logic [LEN_W-1:0] len);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.start = start;
		r.len   = len;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word_start(logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
	endfunction

	// Kind of a one-character mark, KIND_EOF when c is none
	function automatic kind_t single_kind(logic [7:0] c);
		kind_t k;
		case (c)
			8'h2C:   k = KIND_COMMA;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			CH_EQ:   k = KIND_EQUALS;
			8'h2B:   k = KIND_PLUS;
			CH_MINUS: k = KIND_MINUS;
			8'h2A:   k = KIND_STAR;
			8'h2F:   k = KIND_SLASH;
			8'h3B:   k = KIND_SEMI;
			default: k = KIND_EOF;
		endcase
		return k;
	endfunction

	// Keyword lookup; only prefix bytes below the word length are looked at
	function automatic kind_t keyword_kind(prefix_t p, logic [LEN_W-1:0] wlen);
		kind_t k;
		k = KIND_IDENT;
		if (wlen == LEN_W'(4) && p[0] == "f" && p[1] == "u" && p[2] == "n" && p[3] == "c")
			k = KIND_KW_FUNC;
		else if (wlen == LEN_W'(3) && p[0] == "v" && p[1] == "a" && p[2] == "r")
			k = KIND_KW_VAR;
		else if (wlen == LEN_W'(2) && p[0] == "i" && p[1] == "f")
			k = KIND_KW_IF;
		else if (wlen == LEN_W'(6) && p[0] == "r" && p[1] == "e" && p[2] == "t" &&
			p[3] == "u" && p[4] == "r" && p[5] == "n")
			k = KIND_KW_RETURN;
		else if (wlen == LEN_W'(4) && p[0] == "c" && p[1] == "h" && p[2] == "a" && p[3] == "r")
			k = KIND_KW_CHAR;
		else if (wlen == LEN_W'(3) && p[0] == "i" && p[1] == "n" && p[2] == "t")
			k = KIND_KW_INT;
		return k;
	endfunction

endpackage

### rtl/core/source_text_tokenizer.sv
// source_text_tokenizer: streaming lexer, one source byte per item in, tokens out.
// Depends on stt_pkg, stt_result_fifo and source_text_tokenizer_defines.svh.
//
// Source bytes enter on char_code under in_valid/in_ready and are scanned one per
// clock: an input register feeds a single stage of scan logic that updates the
// lexer state and pushes zero, one or two tokens into an eight-entry result queue.
// A byte's tokens reach the outputs through the input register and the result queue,
// and a new byte is taken every cycle while the queue holds four items or fewer, so a
// byte that ends a token and starts another (two results) still flows at one per
// cycle when the consumer keeps out_ready high. last_of_run marks the final token
// caused by a byte. A zero byte flushes any pending token, emits end-of-file and
// returns the lexer to its reset state; after an error token, bytes are ignored
// until the zero byte. Identifiers report offset and length only; offsets wrap at
// 2^16 and lengths saturate at 65535.
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] token_kind,
	output logic [VAL_W-1:0]  int_value,
	output logic [OFS_W-1:0]  start_offset,
	output logic [LEN_W-1:0]  token_length,
	output logic              last_of_run
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_MARK   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_WORD   = 3'd3;
	localparam logic [2:0] MODE_ERROR  = 3'd4;

	logic             valid_s1;
	logic [7:0]       char_s1;

	logic [2:0]       mode_q,   mode_d;
	logic [7:0]       pend_q,   pend_d;
	logic [VAL_W-1:0] acc_q,    acc_d;
	prefix_t          prefix_q, prefix_d;
	logic [LEN_W-1:0] wlen_q,   wlen_d;
	logic [OFS_W-1:0] tstart_q, tstart_d;
	logic [OFS_W-1:0] pos_q,    pos_d;

	logic             fresh;
	logic             rst_all;
	logic [1:0]       n_res;
	res_t             res [2];
	logic [LEN_W-1:0] wlen_inc;
	logic [VAL_W-1:0] digit_val;
	logic             room;
	res_t             head_item;

	assign in_ready  = room;
	assign wlen_inc  = (wlen_q != LEN_MAX) ? LEN_W'(wlen_q + 1'b1) : wlen_q;
	assign digit_val = VAL_W'(char_s1 - CH_ZERO);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			char_s1 <= char_code;
	end

	// scan one byte: continue the token in progress, then scan afresh if it ended
	always_comb begin
		fresh    = 1'b0;
		rst_all  = 1'b0;
		n_res    = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		mode_d   = mode_q;
		pend_d   = pend_q;
		acc_d    = acc_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;
		tstart_d = tstart_q;
		if (valid_s1) begin
			case (mode_q)
				MODE_MARK: begin
					mode_d = MODE_IDLE;
					n_res  = 2'd1;
					if (pend_q == CH_MINUS && char_s1 == CH_GT) begin
						res[0] = mk_res(KIND_ARROW, '0, tstart_q, LEN_W'(2));
					end else if (pend_q == CH_EQ && char_s1 == CH_EQ) begin
						res[0] = mk_res(KIND_EQUALITY, '0, tstart_q, LEN_W'(2));
					end else if (pend_q == CH_BANG && char_s1 == CH_EQ) begin
						res[0] = mk_res(KIND_INEQUALITY, '0, tstart_q, LEN_W'(2));
					end else if (pend_q == CH_MINUS || pend_q == CH_EQ) begin
						res[0] = mk_res((pend_q == CH_MINUS) ? KIND_MINUS : KIND_EQUALS, '0,
							tstart_q, LEN_W'(1));
						fresh  = 1'b1;
					end else begin
						// lone '!'
						res[0] = mk_res(KIND_ERROR, '0, tstart_q, LEN_W'(1));
						mode_d = MODE_ERROR;
						if (char_s1 == CH_NUL) begin
							res[1]  = mk_res(KIND_EOF, '0, pos_q, '0);
							n_res   = 2'd2;
							rst_all = 1'b1;
						end
					end
				end
				MODE_NUMBER: begin
					if (is_digit(char_s1)) begin
						acc_d  = (acc_q << 3) + (acc_q << 1) + digit_val;
						wlen_d = wlen_inc;
					end else begin
						res[0] = mk_res(KIND_INTEGER, acc_q, tstart_q, wlen_q);
						n_res  = 2'd1;
						mode_d = MODE_IDLE;
						fresh  = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_word_start(char_s1) || is_digit(char_s1)) begin
						if (wlen_q < LEN_W'(KW_MAX_LEN))
							prefix_d[wlen_q[KW_IDX_W-1:0]] = char_s1;
						wlen_d = wlen_inc;
					end else begin
						res[0] = mk_res(keyword_kind(prefix_q, wlen_q), '0, tstart_q, wlen_q);
						n_res  = 2'd1;
						mode_d = MODE_IDLE;
						fresh  = 1'b1;
					end
				end
				MODE_ERROR: begin
					if (char_s1 == CH_NUL) begin
						res[0]  = mk_res(KIND_EOF, '0, pos_q, '0);
						n_res   = 2'd1;
						rst_all = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					fresh  = 1'b1;
				end
			endcase

			if (fresh) begin
				if (char_s1 == CH_NUL) begin
					res[n_res[0]] = mk_res(KIND_EOF, '0, pos_q, '0);
					n_res         = n_res + 2'd1;
					rst_all       = 1'b1;
				end else if (is_space(char_s1)) begin
					mode_d = MODE_IDLE;
				end else if (char_s1 == CH_MINUS || char_s1 == CH_EQ || char_s1 == CH_BANG) begin
					mode_d   = MODE_MARK;
					pend_d   = char_s1;
					tstart_d = pos_q;
				end else if (single_kind(char_s1) != KIND_EOF) begin
					res[n_res[0]] = mk_res(single_kind(char_s1), '0, pos_q, LEN_W'(1));
					n_res         = n_res + 2'd1;
				end else if (is_digit(char_s1)) begin
					mode_d   = MODE_NUMBER;
					acc_d    = digit_val;
					wlen_d   = LEN_W'(1);
					tstart_d = pos_q;
				end else if (is_word_start(char_s1)) begin
					mode_d      = MODE_WORD;
					prefix_d[0] = char_s1;
					wlen_d      = LEN_W'(1);
					tstart_d    = pos_q;
				end else begin
					res[n_res[0]] = mk_res(KIND_ERROR, '0, pos_q, LEN_W'(1));
					n_res         = n_res + 2'd1;
					mode_d        = MODE_ERROR;
				end
			end

			if (rst_all) begin
				mode_d   = MODE_IDLE;
				pend_d   = '0;
				acc_d    = '0;
				wlen_d   = '0;
				tstart_d = '0;
			end
		end

		// mark the final result of this byte
		if (n_res == 2'd1)
			res[0].last = 1'b1;
		if (n_res == 2'd2)
			res[1].last = 1'b1;

		if (rst_all)
			pos_d = '0;
		else if (valid_s1)
			pos_d = OFS_W'(pos_q + 1'b1);
		else
			pos_d = pos_q;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pend_q   <= '0;
			acc_q    <= '0;
			wlen_q   <= '0;
			tstart_q <= '0;
			pos_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			acc_q    <= acc_d;
			wlen_q   <= wlen_d;
			tstart_q <= tstart_d;
			pos_q    <= pos_d;
		end
	end

	// keyword prefix: undefined until written
	always_ff @(posedge clk) begin
		prefix_q <= prefix_d;
	end

	// result queue
	stt_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (n_res),
		.item0      (res[0]),
		.item1      (res[1]),
		.room       (room),
		.head_valid (out_valid),
		.head_ready (out_ready),
		.head_item  (head_item)
	);

	assign token_kind   = head_item.kind;
	assign int_value    = head_item.value;
	assign start_offset = head_item.start;
	assign token_length = head_item.len;
	assign last_of_run  = head_item.last;

	`STT_ASSERT(a_error_quiet, !(valid_s1 && mode_q == MODE_ERROR && char_s1 != CH_NUL && n_res != 2'd0), "byte in error mode produced a token")
	`STT_ASSERT_NEXT(a_nul_resets, valid_s1 && char_s1 == CH_NUL, mode_q == MODE_IDLE && pos_q == '0, "zero byte did not reset the lexer")
	`STT_ASSERT(a_eof_last, !(n_res == 2'd2 && res[0].kind == KIND_EOF), "end-of-file token not last of its byte")

endmodule

### rtl/core/stt_result_fifo.sv
// stt_result_fifo: small queue of result items, up to two pushed per cycle.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
`include "source_text_tokenizer_defines.svh"

module stt_result_fifo import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  res_t       item0,
	input  res_t       item1,
	output logic       room,
	output logic       head_valid,
	input  logic       head_ready,
	output res_t       head_item
);

	localparam int IDX_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             mem_q [FIFO_DEPTH];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[head_q];
	assign pop        = head_valid && head_ready;
	// room for one item in the input stage and one in flight, two results each
	assign room       = (count_q <= CNT_W'(FIFO_DEPTH - 4));

	// storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[tail_q] <= item0;
		if (push_cnt == 2'd2)
			mem_q[IDX_W'(tail_q + 1'b1)] <= item1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= IDX_W'(tail_q + IDX_W'(push_cnt));
			if (pop)
				head_q <= IDX_W'(head_q + 1'b1);
			count_q <= CNT_W'(count_q + CNT_W'(push_cnt) - CNT_W'(pop));
		end
	end

	`STT_ASSERT(a_cnt_bound, count_q <= CNT_W'(FIFO_DEPTH), "result queue count out of range")
	`STT_ASSERT(a_push_fits, (CNT_W + 1)'(count_q) + (CNT_W + 1)'(push_cnt) <= (CNT_W + 1)'(FIFO_DEPTH) + (CNT_W + 1)'(pop), "result queue overflow")
	`STT_ASSERT_NEXT(a_head_step, pop, head_q == IDX_W'($past(head_q) + 1'b1), "head did not advance on pop")

endmodule

### bench/stt_token_checker.sv
// stt_token_checker: watches both channels of source_text_tokenizer, predicts the
// tokens of every accepted source byte and compares them with the tokens taken out.
// Depends on stt_pkg for the token kinds, character codes and the result type.
module stt_token_checker import stt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [KIND_W-1:0] token_kind,
	input  logic [VAL_W-1:0]  int_value,
	input  logic [OFS_W-1:0]  start_offset,
	input  logic [LEN_W-1:0]  token_length,
	input  logic              last_of_run,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_MARK,
		LEX_NUMBER,
		LEX_WORD,
		LEX_ERROR
	} lex_mode_e;

	// Lexer state of the prediction
	lex_mode_e        mode;
	logic [7:0]       held_mark;
	logic [VAL_W-1:0] num_acc;
	logic [7:0]       prefix [KW_MAX_LEN];
	logic [LEN_W-1:0] run_len;
	logic [OFS_W-1:0] tok_start;
	logic [OFS_W-1:0] byte_pos;

	res_t token_q[$];
	int   fails;
	int   shown;

	function automatic bit blank_byte(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit word_head(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	// One-character marks other than the lookahead ones
	function automatic bit lone_mark(input logic [7:0] c, output kind_t k);
		lone_mark = 1'b1;
		k = KIND_EOF;
		case (c)
			",":     k = KIND_COMMA;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"+":     k = KIND_PLUS;
			"*":     k = KIND_STAR;
			"/":     k = KIND_SLASH;
			";":     k = KIND_SEMI;
			default: lone_mark = 1'b0;
		endcase
	endfunction

	// Keyword lookup; only words of a keyword's length look at the prefix
	function automatic kind_t word_kind();
		kind_t k;
		k = KIND_IDENT;
		case (run_len)
			16'd2: begin
				if ({prefix[0], prefix[1]} == "if")
					k = KIND_KW_IF;
			end
			16'd3: begin
				if ({prefix[0], prefix[1], prefix[2]} == "var")
					k = KIND_KW_VAR;
				else if ({prefix[0], prefix[1], prefix[2]} == "int")
					k = KIND_KW_INT;
			end
			16'd4: begin
				if ({prefix[0], prefix[1], prefix[2], prefix[3]} == "func")
					k = KIND_KW_FUNC;
				else if ({prefix[0], prefix[1], prefix[2], prefix[3]} == "char")
					k = KIND_KW_CHAR;
			end
			16'd6: begin
				if ({prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]}
					== "return")
					k = KIND_KW_RETURN;
			end
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

	function automatic logic [LEN_W-1:0] sat_step(input logic [LEN_W-1:0] v);
		return (v == LEN_MAX) ? v : v + 1'b1;
	endfunction

	task automatic clear_lexer();
		mode = LEX_IDLE;
		held_mark = CH_NUL;
		num_acc = '0;
		foreach (prefix[i])
			prefix[i] = 8'h00;
		run_len = '0;
		tok_start = '0;
		byte_pos = '0;
	endtask

	task automatic expect_token(input kind_t k, input logic [VAL_W-1:0] v,
		input logic [OFS_W-1:0] s, input logic [LEN_W-1:0] n);
		res_t r;
		r.kind = k;
		r.value = v;
		r.start = s;
		r.len = n;
		r.last = 1'b0;
		token_q.push_back(r);
	endtask

	// Scan a byte with no token in progress; restarted is set by a zero byte
	task automatic scan_fresh(input logic [7:0] c, output bit restarted);
		kind_t k;
		restarted = 1'b0;
		if (c == CH_NUL) begin
			expect_token(KIND_EOF, '0, byte_pos, '0);
			clear_lexer();
			restarted = 1'b1;
		end else if (blank_byte(c)) begin
			// whitespace is dropped
		end else if (c == CH_MINUS || c == CH_EQ || c == CH_BANG) begin
			mode = LEX_MARK;
			held_mark = c;
			tok_start = byte_pos;
		end else if (lone_mark(c, k)) begin
			expect_token(k, '0, byte_pos, 16'd1);
		end else if (digit_byte(c)) begin
			mode = LEX_NUMBER;
			num_acc = VAL_W'(c) - VAL_W'(CH_ZERO);
			run_len = 16'd1;
			tok_start = byte_pos;
		end else if (word_head(c)) begin
			mode = LEX_WORD;
			prefix[0] = c;
			run_len = 16'd1;
			tok_start = byte_pos;
		end else begin
			expect_token(KIND_ERROR, '0, byte_pos, 16'd1);
			mode = LEX_ERROR;
		end
	endtask

	// Predict the tokens of one accepted source byte
	task automatic lex_byte(input logic [7:0] c);
		int   n0;
		bit   rescan;
		bit   restarted;
		res_t tail;
		n0 = token_q.size();
		rescan = 1'b0;
		restarted = 1'b0;
		case (mode)
			LEX_MARK: begin
				mode = LEX_IDLE;
				if (held_mark == CH_MINUS && c == CH_GT)
					expect_token(KIND_ARROW, '0, tok_start, 16'd2);
				else if (held_mark == CH_EQ && c == CH_EQ)
					expect_token(KIND_EQUALITY, '0, tok_start, 16'd2);
				else if (held_mark == CH_BANG && c == CH_EQ)
					expect_token(KIND_INEQUALITY, '0, tok_start, 16'd2);
				else if (held_mark == CH_MINUS || held_mark == CH_EQ) begin
					// pending one-byte mark goes out, the byte is scanned again
					expect_token(held_mark == CH_MINUS ? KIND_MINUS : KIND_EQUALS, '0,
						tok_start, 16'd1);
					rescan = 1'b1;
				end else begin
					// bang not followed by '='
					expect_token(KIND_ERROR, '0, tok_start, 16'd1);
					mode = LEX_ERROR;
					if (c == CH_NUL) begin
						expect_token(KIND_EOF, '0, byte_pos, '0);
						clear_lexer();
						restarted = 1'b1;
					end
				end
			end
			LEX_NUMBER: begin
				if (digit_byte(c)) begin
					num_acc = num_acc * 64'd10 + (VAL_W'(c) - VAL_W'(CH_ZERO));
					run_len = sat_step(run_len);
				end else begin
					expect_token(KIND_INTEGER, num_acc, tok_start, run_len);
					mode = LEX_IDLE;
					rescan = 1'b1;
				end
			end
			LEX_WORD: begin
				if (word_head(c) || digit_byte(c)) begin
					if (run_len < KW_MAX_LEN)
						prefix[run_len[KW_IDX_W-1:0]] = c;
					run_len = sat_step(run_len);
				end else begin
					expect_token(word_kind(), '0, tok_start, run_len);
					mode = LEX_IDLE;
					rescan = 1'b1;
				end
			end
			LEX_ERROR: begin
				if (c == CH_NUL) begin
					expect_token(KIND_EOF, '0, byte_pos, '0);
					clear_lexer();
					restarted = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase
		if (rescan)
			scan_fresh(c, restarted);
		if (!restarted)
			byte_pos = byte_pos + 1'b1;
		// flag the final token of this byte
		if (token_q.size() > n0) begin
			tail = token_q.pop_back();
			tail.last = 1'b1;
			token_q.push_back(tail);
		end
	endtask

	initial
		clear_lexer();

	// Predict on accepted source bytes, compare on accepted tokens
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			clear_lexer();
			token_q.delete();
		end else begin
			if (in_valid && in_ready)
				lex_byte(char_code);
			if (out_valid && out_ready) begin
				got.kind = token_kind;
				got.value = int_value;
				got.start = start_offset;
				got.len = token_length;
				got.last = last_of_run;
				if (token_q.size() == 0) begin
					fails++;
					if (shown < 10) begin
						shown++;
						$display("token check: unexpected token kind %0d start %0d len %0d",
							got.kind, got.start, got.len);
					end
				end else begin
					want = token_q.pop_front();
					if (got.kind !== want.kind || got.value !== want.value ||
						got.start !== want.start || got.len !== want.len ||
						got.last !== want.last) begin
						fails++;
						if (shown < 10) begin
							shown++;
							$display("token check: expected kind %0d value %0d start %0d len %0d last %0d",
								want.kind, want.value, want.start, want.len, want.last);
							$display("token check: got      kind %0d value %0d start %0d len %0d last %0d",
								got.kind, got.value, got.start, got.len, got.last);
						end
					end
				end
			end
		end
		fail_count <= fails;
		pending <= token_q.size();
	end

endmodule

### bench/tb_source_text_tokenizer.sv
// tb_source_text_tokenizer: clock, reset and source-byte stimulus for the tokenizer,
// random flow control on both channels and the final verdict.
// Depends on stt_pkg, source_text_tokenizer and stt_token_checker.
module tb_source_text_tokenizer;
	import stt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 400;
	localparam int PRESSURE_LEN = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic       rush;
		logic [7:0] code;
	} stim_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        char_code;
	logic              out_valid;
	logic              out_ready;
	logic [KIND_W-1:0] token_kind;
	logic [VAL_W-1:0]  int_value;
	logic [OFS_W-1:0]  start_offset;
	logic [LEN_W-1:0]  token_length;
	logic              last_of_run;
	int                fail_count;
	int                pending;

	stim_t      feed_q[$];
	string      kw_list [6] = '{"func", "var", "if", "return", "char", "int"};
	logic [7:0] mark_set [11] = '{",", "(", ")", "{", "}", "=", "+", "-", "*", "/", ";"};
	logic [7:0] blank_set [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

	source_text_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.int_value    (int_value),
		.start_offset (start_offset),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	stt_token_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.int_value    (int_value),
		.start_offset (start_offset),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Clock and reset
	initial
		clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] word_char(input bit with_digit);
		int r;
		r = $urandom_range(0, with_digit ? 62 : 52);
		if (r < 26)
			return 8'(r) + "a";
		if (r < 52)
			return 8'(r - 26) + "A";
		if (r == 52)
			return "_";
		return 8'(r - 53) + "0";
	endfunction

	task automatic push_code(input logic [7:0] c, input bit rush);
		stim_t s;
		s.rush = rush;
		s.code = c;
		feed_q.push_back(s);
	endtask

	task automatic feed_text(input string s, input bit rush);
		int k;
		for (k = 0; k < s.len(); k++)
			push_code(s[k], rush);
	endtask

	// One text with random content, ended by a zero byte
	task automatic feed_phrase();
		int    n_tok;
		int    cat;
		int    pick;
		int    len;
		int    k;
		string kw;
		n_tok = $urandom_range(2, 10);
		repeat (n_tok) begin
			cat = $urandom_range(0, 11);
			case (cat)
				0, 1, 2: begin
					// keyword, sometimes cut short or run on by one byte
					kw = kw_list[$urandom_range(0, 5)];
					pick = $urandom_range(0, 5);
					len = (pick == 0) ? kw.len() - 1 : kw.len();
					for (k = 0; k < len; k++)
						push_code(kw[k], 1'b0);
					if (pick == 1)
						push_code(word_char(1'b1), 1'b0);
				end
				3, 4: begin
					len = $urandom_range(1, 9);
					push_code(word_char(1'b0), 1'b0);
					repeat (len - 1)
						push_code(word_char(1'b1), 1'b0);
				end
				5, 6: begin
					// integers, including the top value and the first wrap
					pick = $urandom_range(0, 9);
					if (pick == 0)
						feed_text("0", 1'b0);
					else if (pick == 1)
						feed_text("18446744073709551615", 1'b0);
					else if (pick == 2)
						feed_text("18446744073709551616", 1'b0);
					else begin
						len = $urandom_range(1, 24);
						repeat (len)
							push_code(8'($urandom_range(0, 9)) + "0", 1'b0);
					end
				end
				7, 8: push_code(mark_set[$urandom_range(0, 10)], 1'b0);
				9: begin
					pick = $urandom_range(0, 2);
					if (pick == 0)
						feed_text("->", 1'b0);
					else if (pick == 1)
						feed_text("==", 1'b0);
					else
						feed_text("!=", 1'b0);
				end
				10: begin
					// lookahead mark left to whatever follows
					pick = $urandom_range(0, 2);
					push_code(pick == 0 ? CH_MINUS : (pick == 1 ? CH_EQ : CH_BANG), 1'b0);
				end
				default: push_code(8'($urandom_range(1, 255)), 1'b0);
			endcase
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(1, 3);
				repeat (pick)
					push_code(blank_set[$urandom_range(0, 3)], 1'b0);
			end
		end
		push_code(CH_NUL, 1'b0);
	endtask

	// Random bytes of any value, then a zero byte
	task automatic feed_noise();
		int len;
		len = $urandom_range(3, 12);
		repeat (len)
			push_code(8'($urandom_range(0, 255)), 1'b0);
		push_code(CH_NUL, 1'b0);
	endtask

	task automatic build_stimulus();
		int base;
		// every mark, the double marks, integer ended by a word, lone bang and
		// error mode, bang before zero, pending minus before zero
		feed_text(",(){}=+-*/;->==!=7q!x", 1'b0);
		push_code(CH_NUL, 1'b0);
		push_code(CH_BANG, 1'b0);
		push_code(CH_NUL, 1'b0);
		push_code(CH_MINUS, 1'b0);
		push_code(CH_NUL, 1'b0);
		base = feed_q.size();
		while (feed_q.size() - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0)
				feed_noise();
			else
				feed_phrase();
		end
	endtask

	// Source side: offer items with random gaps, then wait out the tokens
	initial begin : feed
		stim_t s;
		int    gap;
		int    sent;
		bit    calm;
		in_valid = 1'b0;
		char_code = 8'h00;
		build_stimulus();
		wait (arst_n === 1'b1);
		@(posedge clk);
		sent = 0;
		calm = 1'b0;
		while (feed_q.size() > 0) begin
			s = feed_q.pop_front();
			if (sent % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			gap = (s.rush || calm) ? 0 : idle_len();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			char_code <= s.code;
			do
				@(posedge clk);
			while (!in_ready);
			sent++;
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("source_text_tokenizer regression: pass");
		else
			$display("source_text_tokenizer regression: fail");
		$finish;
	end

	// Token side: random stalls, one long hold-off to fill the block
	initial begin : drain
		int hold;
		int taken;
		int tick;
		bit pressed;
		bit calm;
		out_ready = 1'b0;
		hold = 0;
		taken = 0;
		tick = 0;
		pressed = 1'b0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			tick++;
			if (tick % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (!pressed && taken >= 40) begin
				pressed = 1'b1;
				hold = PRESSURE_LEN;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm)
					hold = idle_len();
			end
		end
	end

	// Run limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("source_text_tokenizer regression: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/stt_pkg.sv
rtl/core/stt_result_fifo.sv
rtl/core/source_text_tokenizer.sv
bench/stt_token_checker.sv
bench/tb_source_text_tokenizer.sv
